[sv/rtp_pkg.sv]
// ----------------------------------------------------------------------------
// rtp_pkg
// Shared types and constants for the RTP reorder tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package rtp_pkg;

  localparam int unsigned SLOT_COUNT   = 1024;
  localparam int unsigned SLOT_AW      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned CLR_W        = $clog2(SLOT_COUNT + 1);
  localparam int unsigned HEADER_BYTES = 12;
  localparam logic [1:0]  VALID_VER    = 2'd2;

  localparam int unsigned SEQ_W   = 16;
  localparam int unsigned LEN_W   = 16;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned BYTE_W  = 48;
  localparam int unsigned HIGH_W  = 11;

  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 168;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_DUP     = 3'd1,
    ST_RANGE   = 3'd2,
    ST_VERSION = 3'd3,
    ST_SHORT   = 3'd4
  } status_e;

endpackage

`default_nettype wire

[sv/rtp_ram.sv]
// ----------------------------------------------------------------------------
// rtp_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module rtp_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Hold read data until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[sv/rtp_reorder_tracker.sv]
// ----------------------------------------------------------------------------
// rtp_reorder_tracker
// Sequence bookkeeping for a received RTP stream: duplicate and reorder
// detection over a seen-bit map, plus running packet and byte statistics.
// ----------------------------------------------------------------------------
// After reset the block sweeps its 1024-entry seen-bit RAM to zero, one entry
// per cycle, and holds s_axis_tready low until the sweep is done. From then on
// it takes one packet header per cycle while stage 1 can advance: the header is
// accepted and its seen bit is read from the RAM through the registered read
// port. With stage 1 holding the header the checks run; when stage 1 advances,
// the bit is written back and the result lands in the output register. The
// result is therefore valid in the cycle after stage 1 advances. A write that
// collides with the read of the following packet is forwarded. The output
// register stalls the pipeline only while it holds a result and m_axis_tready is low.
// ----------------------------------------------------------------------------
`default_nettype none

module rtp_reorder_tracker (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // tdata: version[1:0], seq_num[17:2], pkt_len[33:18]
  input  wire logic [rtp_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  input  wire logic                            s_axis_tlast,   // marker_bit
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // tdata: out_of_order[0], rx_count[32:1], payload_bytes[80:33],
  //        duplicates_seen[112:81], reordered_seen[144:113],
  //        highest_count[155:145], missing_count[166:156]
  output logic [rtp_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
  output logic [2:0]                           m_axis_tuser,   // status
  output logic                                 m_axis_tlast,   // end_of_stream
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready
);

  localparam int unsigned AW = rtp_pkg::SLOT_AW;

  // Clearing sweep
  logic [rtp_pkg::CLR_W-1:0] clr_q, clr_d;
  logic                      clr_done;

  // Input decode
  logic [1:0]                 in_ver;
  logic [rtp_pkg::SEQ_W-1:0]  in_seq, in_seq_m1;
  logic [rtp_pkg::LEN_W-1:0]  in_len;
  logic                       s_xfer;

  // Stage 1
  logic                       s1_valid_q, s1_valid_d;
  logic [1:0]                 s1_ver_q;
  logic                       s1_mark_q;
  logic [rtp_pkg::SEQ_W-1:0]  s1_seq_q;
  logic [rtp_pkg::LEN_W-1:0]  s1_len_q;
  logic [AW-1:0]              s1_addr_q;
  logic                       s1_fwd_q;
  logic                       s1_adv;

  // Counters
  logic [rtp_pkg::CNT_W-1:0]  acc_q, acc_d;
  logic [rtp_pkg::BYTE_W-1:0] byte_q, byte_d;
  logic [rtp_pkg::CNT_W-1:0]  dup_q, dup_d;
  logic [rtp_pkg::CNT_W-1:0]  reord_q, reord_d;
  logic [rtp_pkg::HIGH_W-1:0] high_q, high_d;

  // Evaluation
  rtp_pkg::status_e           status;
  logic                       seen, ok, ooo;
  logic [rtp_pkg::LEN_W-1:0]  payload_len;
  logic [rtp_pkg::HIGH_W-1:0] missing;

  // RAM ports
  logic          ram_we, ram_wdata, ram_rdata;
  logic [AW-1:0] ram_waddr, ram_raddr;

  // Output register
  logic                          out_valid_q;
  logic [rtp_pkg::OUT_DATA_W-1:0] out_data_q;
  logic [2:0]                    out_user_q;
  logic                          out_last_q;

  assign clr_done = (clr_q == rtp_pkg::CLR_W'(rtp_pkg::SLOT_COUNT));
  assign clr_d    = clr_done ? clr_q : clr_q + rtp_pkg::CLR_W'(1);

  assign in_ver    = s_axis_tdata[1:0];
  assign in_seq    = s_axis_tdata[17:2];
  assign in_len    = s_axis_tdata[33:18];
  assign in_seq_m1 = in_seq - rtp_pkg::SEQ_W'(1);

  assign s1_adv        = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = clr_done && (!s1_valid_q || s1_adv);
  assign s_xfer        = s_axis_tvalid && s_axis_tready;
  assign s1_valid_d    = s_xfer ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);

  // Seen-bit RAM: sweep zeros after reset, then mark accepted slots.
  assign ram_raddr = in_seq_m1[AW-1:0];
  assign ram_we    = !clr_done || (s1_adv && ok);
  assign ram_waddr = clr_done ? s1_addr_q : clr_q[AW-1:0];
  assign ram_wdata = clr_done;

  rtp_ram #(
    .WIDTH (1),
    .DEPTH (rtp_pkg::SLOT_COUNT)
  ) u_seen_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (s_xfer),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Checks, in priority order.
  assign seen = ram_rdata || s1_fwd_q;

  always_comb begin
    if (s1_len_q < rtp_pkg::LEN_W'(rtp_pkg::HEADER_BYTES)) begin
      status = rtp_pkg::ST_SHORT;
    end else if (s1_ver_q != rtp_pkg::VALID_VER) begin
      status = rtp_pkg::ST_VERSION;
    end else if (s1_seq_q == '0 ||
                 s1_seq_q > rtp_pkg::SEQ_W'(rtp_pkg::SLOT_COUNT)) begin
      status = rtp_pkg::ST_RANGE;
    end else if (seen) begin
      status = rtp_pkg::ST_DUP;
    end else begin
      status = rtp_pkg::ST_OK;
    end
  end

  assign ok          = (status == rtp_pkg::ST_OK);
  assign ooo         = ok && (s1_seq_q < rtp_pkg::SEQ_W'(high_q));
  assign payload_len = s1_len_q - rtp_pkg::LEN_W'(rtp_pkg::HEADER_BYTES);

  assign acc_d   = acc_q + rtp_pkg::CNT_W'(ok);
  assign byte_d  = ok ? byte_q + rtp_pkg::BYTE_W'(payload_len) : byte_q;
  assign dup_d   = dup_q + rtp_pkg::CNT_W'(status == rtp_pkg::ST_DUP);
  assign reord_d = reord_q + rtp_pkg::CNT_W'(ooo);
  assign high_d  = (ok && s1_seq_q > rtp_pkg::SEQ_W'(high_q)) ?
                   s1_seq_q[rtp_pkg::HIGH_W-1:0] : high_q;
  assign missing = high_d - acc_d[rtp_pkg::HIGH_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      s1_valid_q  <= 1'b0;
      acc_q       <= '0;
      byte_q      <= '0;
      dup_q       <= '0;
      reord_q     <= '0;
      high_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      clr_q      <= clr_d;
      s1_valid_q <= s1_valid_d;
      if (s1_adv) begin
        acc_q   <= acc_d;
        byte_q  <= byte_d;
        dup_q   <= dup_d;
        reord_q <= reord_d;
        high_q  <= high_d;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers; forward a same-cycle write to the slot being read.
  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      s1_ver_q  <= in_ver;
      s1_mark_q <= s_axis_tlast;
      s1_seq_q  <= in_seq;
      s1_len_q  <= in_len;
      s1_addr_q <= ram_raddr;
      s1_fwd_q  <= ram_we && (ram_waddr == ram_raddr);
    end
    if (s1_adv) begin
      out_user_q <= status;
      out_last_q <= ok && s1_mark_q;
      out_data_q <= {1'b0, missing, high_d, reord_d, dup_d, byte_d, acc_d, ooo};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;
  assign m_axis_tlast  = out_last_q;

  // Assertions
  a_no_xfer_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> clr_done)
    else $error("input taken during seen-bit sweep");

  a_accept_only_unseen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && ok) |-> !ram_rdata && !s1_fwd_q)
    else $error("slot accepted although already marked");

  a_high_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> (high_q >= $past(high_q)))
    else $error("highest count decreased");

  a_missing_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[166:156] ==
                       m_axis_tdata[155:145] - m_axis_tdata[11:1]))
    else $error("missing count mismatch");

  a_stage_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s_xfer && (!out_valid_q || m_axis_tready)) |=> !s1_valid_q)
    else $error("stage 1 held without backpressure");

endmodule

`default_nettype wire

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for rtp_reorder_tracker. Packet headers go in over the
// slave stream, and each transfer is scored against an in-bench tracker of
// the seen-slot map and the running counters. Each result on the master
// stream is then checked field by field. Both ends idle at random; there is
// one long receiver hold and two sender pauses that drain the block.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_PKTS = 1630;
  localparam int unsigned HOLD_AT     = 500;
  localparam int unsigned HOLD_CYCLES = 400;

  typedef struct {
    logic [1:0]  ver;
    logic        marker;
    logic [15:0] seq;
    logic [15:0] len;
    bit          drain;   // wait for every due result before this transfer
  } pkt_t;

  typedef struct {
    rtp_pkg::status_e status;
    logic        ooo;
    logic        eos;
    logic [31:0] rx_pkts;
    logic [47:0] bytes;
    logic [31:0] dups;
    logic [31:0] reords;
    logic [10:0] high;
    logic [10:0] miss;
  } res_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic [rtp_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                           s_axis_tlast = 1'b0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [rtp_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic [2:0]                     m_axis_tuser;
  logic                           m_axis_tlast;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;

  rtp_reorder_tracker uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
  );

  always #5 clk_i = ~clk_i;

  // Tracker state
  bit          seen_map [rtp_pkg::SLOT_COUNT];
  logic [10:0] top_seq = '0;
  logic [31:0] good_total = '0;
  logic [47:0] byte_total = '0;
  logic [31:0] dup_total = '0;
  logic [31:0] reord_total = '0;

  pkt_t pending[$];
  res_t due_results[$];
  int   total_pkts = 0;
  int   sent_cnt = 0;
  int   rx_cnt = 0;
  int   mism = 0;
  int   status_hits [5] = '{default: 0};
  int   ooo_hits = 0;
  int   eos_hits = 0;
  logic in_fire = 1'b0;
  int   send_gap = 0;
  int   stall_left = 0;
  int   hold_left = 0;
  bit   hold_done = 1'b0;

  function automatic res_t track_packet(logic [1:0] ver, logic mark, logic [15:0] seq,
                                        logic [15:0] len);
    res_t r;
    r.ooo = 1'b0;
    r.eos = 1'b0;
    if (len < rtp_pkg::HEADER_BYTES) begin
      r.status = rtp_pkg::ST_SHORT;
    end else if (ver != rtp_pkg::VALID_VER) begin
      r.status = rtp_pkg::ST_VERSION;
    end else if (seq == 0 || seq > rtp_pkg::SLOT_COUNT) begin
      r.status = rtp_pkg::ST_RANGE;
    end else if (seen_map[seq - 1]) begin
      r.status  = rtp_pkg::ST_DUP;
      dup_total = dup_total + 1;
    end else begin
      r.status = rtp_pkg::ST_OK;
      if (seq < top_seq) begin
        r.ooo       = 1'b1;
        reord_total = reord_total + 1;
      end
      seen_map[seq - 1] = 1'b1;
      good_total = good_total + 1;
      byte_total = byte_total + 48'(len - rtp_pkg::HEADER_BYTES);
      if (seq > top_seq) top_seq = seq[10:0];
      r.eos = mark;
    end
    r.rx_pkts = good_total;
    r.bytes   = byte_total;
    r.dups    = dup_total;
    r.reords  = reord_total;
    r.high    = top_seq;
    r.miss    = top_seq - good_total[10:0];
    return r;
  endfunction

  function automatic void check_field(string fname, logic [47:0] want, logic [47:0] got);
    if (want !== got) begin
      mism++;
      if (mism <= 10)
        $display("mismatch on result %0d, %s: expected 0x%0h, got 0x%0h",
                 rx_cnt, fname, want, got);
    end
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 1;
    if (r < 88) return $urandom_range(2, 4);
    if (r < 98) return $urandom_range(5, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic add_pkt(logic [1:0] ver, logic mark, logic [15:0] seq, logic [15:0] len);
    pkt_t p;
    p.ver    = ver;
    p.marker = mark;
    p.seq    = seq;
    p.len    = len;
    p.drain  = 1'b0;
    pending.push_back(p);
    total_pkts++;
  endtask

  // Sender: present the next packet at the falling edge
  always @(negedge clk_i) begin : drive
    pkt_t p;
    logic nv;
    nv = 1'b0;
    if (rst_ni) begin
      if (s_axis_tvalid && !in_fire) begin
        nv = 1'b1;
      end else if (send_gap > 0) begin
        send_gap--;
      end else if (pending.size() > 0 && !(pending[0].drain && due_results.size() > 0)) begin
        p = pending.pop_front();
        s_axis_tdata <= {6'd0, p.len, p.seq, p.ver};
        s_axis_tlast <= p.marker;
        nv = 1'b1;
        if (((sent_cnt / 128) % 3) != 0 && $urandom_range(0, 1) == 1)
          send_gap = pick_gap();
      end
    end
    s_axis_tvalid <= nv;
  end

  // Score each input transfer
  always @(posedge clk_i) begin : score
    res_t e;
    in_fire <= rst_ni && s_axis_tvalid && s_axis_tready;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      e = track_packet(s_axis_tdata[1:0], s_axis_tlast, s_axis_tdata[17:2],
                       s_axis_tdata[33:18]);
      status_hits[e.status]++;
      ooo_hits += e.ooo;
      eos_hits += e.eos;
      due_results.push_back(e);
      sent_cnt++;
    end
  end

  // Receiver: random stalls, plus one long hold that backs up the input
  always @(negedge clk_i) begin : sink
    logic nr;
    nr = 1'b1;
    if (hold_left > 0) begin
      nr = 1'b0;
      hold_left--;
    end else if (!hold_done && rx_cnt >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      nr = 1'b0;
    end else if (stall_left > 0) begin
      nr = 1'b0;
      stall_left--;
    end else if (((rx_cnt / 128) % 3) != 1 && $urandom_range(0, 99) < 25) begin
      stall_left = pick_gap() - 1;
      nr = 1'b0;
    end
    m_axis_tready <= nr;
  end

  // Check each output transfer against the oldest due result
  always @(posedge clk_i) begin : check
    res_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      rx_cnt++;
      if (due_results.size() == 0) begin
        mism++;
        if (mism <= 10) $display("unexpected result %0d with nothing due", rx_cnt);
      end else begin
        e = due_results.pop_front();
        check_field("status", 48'(e.status), 48'(m_axis_tuser));
        check_field("out_of_order", 48'(e.ooo), 48'(m_axis_tdata[0]));
        check_field("end_of_stream", 48'(e.eos), 48'(m_axis_tlast));
        check_field("rx_count", 48'(e.rx_pkts), 48'(m_axis_tdata[32:1]));
        check_field("payload_bytes", e.bytes, m_axis_tdata[80:33]);
        check_field("duplicates_seen", 48'(e.dups), 48'(m_axis_tdata[112:81]));
        check_field("reordered_seen", 48'(e.reords), 48'(m_axis_tdata[144:113]));
        check_field("highest_count", 48'(e.high), 48'(m_axis_tdata[155:145]));
        check_field("missing_count", 48'(e.miss), 48'(m_axis_tdata[166:156]));
      end
    end
  end

  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    int          fwd_ptr;
    int          holes[$];
    int          r;
    int          skip;
    int          idx;
    int          top;
    logic [15:0] seq;
    logic [15:0] len;
    logic [1:0]  ver;
    logic        mark;

    // Directed: rejections, check order, first packet, duplicates, reordering
    add_pkt(rtp_pkg::VALID_VER, 1'b0, 16'd1, 16'd0);
    add_pkt(rtp_pkg::VALID_VER, 1'b1, 16'd1, 16'd11);
    add_pkt(2'd0, 1'b0, 16'd1, 16'd12);
    add_pkt(2'd1, 1'b0, 16'd1, 16'd40);
    add_pkt(2'd3, 1'b1, 16'd1, 16'd65535);
    add_pkt(rtp_pkg::VALID_VER, 1'b0, 16'd0, 16'd20);
    add_pkt(rtp_pkg::VALID_VER, 1'b0, 16'd1025, 16'd20);
    add_pkt(rtp_pkg::VALID_VER, 1'b1, 16'd65535, 16'd20);
    add_pkt(rtp_pkg::VALID_VER, 1'b0, 16'd1, 16'd12);
    add_pkt(rtp_pkg::VALID_VER, 1'b1, 16'd1, 16'd12);
    add_pkt(rtp_pkg::VALID_VER, 1'b0, 16'd5, 16'd65535);
    add_pkt(rtp_pkg::VALID_VER, 1'b0, 16'd3, 16'd100);
    add_pkt(rtp_pkg::VALID_VER, 1'b1, 16'd4, 16'd13);
    add_pkt(rtp_pkg::VALID_VER, 1'b0, 16'd5, 16'd64);
    add_pkt(rtp_pkg::VALID_VER, 1'b0, 16'd4, 16'd5);
    add_pkt(2'd3, 1'b0, 16'd6, 16'd100);
    add_pkt(2'd0, 1'b0, 16'd0, 16'd3);
    add_pkt(2'd1, 1'b0, 16'd0, 16'd30);
    add_pkt(rtp_pkg::VALID_VER, 1'b0, 16'd2, 16'd1500);
    add_pkt(rtp_pkg::VALID_VER, 1'b1, 16'd6, 16'd200);

    // Random: a forward-walking stream with skips, late fills, repeats and noise
    fwd_ptr = 7;
    for (int n = 0; n < RANDOM_PKTS; n++) begin
      r    = $urandom_range(0, 99);
      ver  = rtp_pkg::VALID_VER;
      mark = ($urandom_range(0, 99) < 3);
      len  = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(12, 65535))
                                          : 16'($urandom_range(12, 1500));
      top  = (fwd_ptr > rtp_pkg::SLOT_COUNT) ? rtp_pkg::SLOT_COUNT : fwd_ptr - 1;
      seq  = 16'($urandom_range(1, top));
      if (r < 55) begin
        if (fwd_ptr <= rtp_pkg::SLOT_COUNT) begin
          seq  = 16'(fwd_ptr);
          skip = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 3);
          for (int k = 1; k <= skip; k++)
            if (fwd_ptr + k <= rtp_pkg::SLOT_COUNT) holes.push_back(fwd_ptr + k);
          fwd_ptr += 1 + skip;
        end
      end else if (r < 75) begin
        if (holes.size() > 0) begin
          idx = $urandom_range(0, holes.size() - 1);
          seq = 16'(holes[idx]);
          holes.delete(idx);
        end
      end else if (r >= 85) begin
        ver  = 2'($urandom_range(0, 3));
        mark = 1'($urandom_range(0, 1));
        seq  = 16'($urandom);
        len  = ($urandom_range(0, 1) == 1) ? 16'($urandom) : 16'($urandom_range(0, 11));
      end
      add_pkt(ver, mark, seq, len);
      if (n == 0 || n == RANDOM_PKTS / 2) pending[pending.size() - 1].drain = 1'b1;
    end

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    wait (sent_cnt == total_pkts);
    wait (due_results.size() == 0);
    repeat (8) @(posedge clk_i);

    $display("sent %0d packet headers: %0d accepted (%0d out of order, %0d end of stream),",
             total_pkts, status_hits[rtp_pkg::ST_OK], ooo_hits, eos_hits);
    $display("%0d duplicates, %0d out of range, %0d bad version, %0d too short; %0d mismatches",
             status_hits[rtp_pkg::ST_DUP], status_hits[rtp_pkg::ST_RANGE],
             status_hits[rtp_pkg::ST_VERSION], status_hits[rtp_pkg::ST_SHORT], mism);
    if (mism == 0 && due_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
